### hdl/jsu_pkg.sv
// Shared types, codes and helper functions for the JSON string unescaper.
package jsu_pkg;

    typedef enum logic [6:0] {
        MODE_IDLE    = 7'b0000001,
        MODE_BODY    = 7'b0000010,
        MODE_ESC     = 7'b0000100,
        MODE_HEX1    = 7'b0001000,
        MODE_PAIR_BS = 7'b0010000,
        MODE_PAIR_U  = 7'b0100000,
        MODE_HEX2    = 7'b1000000
    } mode_t;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_CONTROL  = 3'd1;
    localparam logic [2:0] ERR_ESCAPE   = 3'd2;
    localparam logic [2:0] ERR_HEX      = 3'd3;
    localparam logic [2:0] ERR_EARLY    = 3'd4;
    localparam logic [2:0] ERR_PAIR     = 3'd5;
    localparam logic [2:0] ERR_STRAY_LO = 3'd6;
    localparam logic [2:0] ERR_MAX      = ERR_STRAY_LO;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CTRL_MAX = 8'h1F;

    typedef struct packed {
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic [7:0] byte_c;
        logic [7:0] byte_d;
        logic [2:0] byte_count;
        logic       string_done;
        logic [2:0] error_code;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_digit(input logic [7:0] c);
        hex_t h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.value = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            h.value = c[3:0] + 4'd9;
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic result_t utf8_encode(input logic [20:0] cp);
        result_t r;
        r = '0;
        if (cp <= 21'h7F)
        begin
            r.byte_a     = cp[7:0];
            r.byte_count = 3'd1;
        end
        else if (cp <= 21'h7FF)
        begin
            r.byte_a     = {3'b110, cp[10:6]};
            r.byte_b     = {2'b10, cp[5:0]};
            r.byte_count = 3'd2;
        end
        else if (cp <= 21'hFFFF)
        begin
            r.byte_a     = {4'b1110, cp[15:12]};
            r.byte_b     = {2'b10, cp[11:6]};
            r.byte_c     = {2'b10, cp[5:0]};
            r.byte_count = 3'd3;
        end
        else
        begin
            r.byte_a     = {5'b11110, cp[20:18]};
            r.byte_b     = {2'b10, cp[17:12]};
            r.byte_c     = {2'b10, cp[11:6]};
            r.byte_d     = {2'b10, cp[5:0]};
            r.byte_count = 3'd4;
        end
        return r;
    endfunction

endpackage

### hdl/jsu_step.sv
// Scan mode machine: decodes one byte per step and builds its result.
module jsu_step import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] c,
    input  logic       ended,
    output logic       res_valid,
    output result_t    res
);

    mode_t       mode_reg, mode_next;
    logic [1:0]  hex_count_reg, hex_count_next;
    logic [15:0] hex_value_reg, hex_value_next;
    logic [9:0]  high_part_reg, high_part_next;

    hex_t        hd;
    logic [15:0] hv;
    logic [20:0] pair_cp;
    logic        active;

    assign hd      = hex_digit(c);
    assign hv      = {hex_value_reg[11:0], hd.value};
    assign pair_cp = 21'h10000 + {1'b0, high_part_reg, hv[9:0]};
    assign active  = (mode_reg == MODE_BODY) || (mode_reg == MODE_ESC)
                  || (mode_reg == MODE_HEX1) || (mode_reg == MODE_PAIR_BS)
                  || (mode_reg == MODE_PAIR_U) || (mode_reg == MODE_HEX2);

    always_comb
    begin
        mode_next      = mode_reg;
        hex_count_next = hex_count_reg;
        hex_value_next = hex_value_reg;
        high_part_next = high_part_reg;
        res_valid      = 1'b0;
        res            = '0;

        if (!active)
        begin
            mode_next = ended ? MODE_IDLE : MODE_BODY;
        end
        else if (ended)
        begin
            res_valid      = 1'b1;
            res.error_code = ERR_EARLY;
        end
        else
        begin
            unique case (mode_reg)
                MODE_BODY:
                begin
                    res_valid = 1'b1;
                    if (c == CH_QUOTE)
                    begin
                        res.string_done = 1'b1;
                    end
                    else if (c <= CTRL_MAX)
                    begin
                        res.error_code = ERR_CONTROL;
                    end
                    else if (c == CH_BSL)
                    begin
                        res_valid = 1'b0;
                        mode_next = MODE_ESC;
                    end
                    else
                    begin
                        res.byte_a     = c;
                        res.byte_count = 3'd1;
                    end
                end
                MODE_ESC:
                begin
                    res_valid      = 1'b1;
                    res.byte_count = 3'd1;
                    mode_next      = MODE_BODY;
                    case (c)
                        8'h22:   res.byte_a = 8'h22;
                        8'h5C:   res.byte_a = 8'h5C;
                        8'h2F:   res.byte_a = 8'h2F;
                        8'h62:   res.byte_a = 8'h08;
                        8'h66:   res.byte_a = 8'h0C;
                        8'h6E:   res.byte_a = 8'h0A;
                        8'h72:   res.byte_a = 8'h0D;
                        8'h74:   res.byte_a = 8'h09;
                        CH_U:
                        begin
                            res_valid      = 1'b0;
                            res.byte_count = 3'd0;
                            mode_next      = MODE_HEX1;
                            hex_count_next = 2'd0;
                            hex_value_next = 16'd0;
                        end
                        default:
                        begin
                            res.byte_count = 3'd0;
                            res.error_code = ERR_ESCAPE;
                        end
                    endcase
                end
                MODE_PAIR_BS:
                begin
                    if (c != CH_BSL)
                    begin
                        res_valid      = 1'b1;
                        res.error_code = ERR_PAIR;
                    end
                    else
                    begin
                        mode_next = MODE_PAIR_U;
                    end
                end
                MODE_PAIR_U:
                begin
                    if (c != CH_U)
                    begin
                        res_valid      = 1'b1;
                        res.error_code = ERR_PAIR;
                    end
                    else
                    begin
                        mode_next      = MODE_HEX2;
                        hex_count_next = 2'd0;
                        hex_value_next = 16'd0;
                    end
                end
                default:
                begin
                    // HEX1 or HEX2
                    if (!hd.ok)
                    begin
                        res_valid      = 1'b1;
                        res.error_code = ERR_HEX;
                    end
                    else if (hex_count_reg != 2'd3)
                    begin
                        hex_value_next = hv;
                        hex_count_next = hex_count_reg + 2'd1;
                    end
                    else if (mode_reg == MODE_HEX1)
                    begin
                        hex_count_next = 2'd0;
                        hex_value_next = 16'd0;
                        if (hv >= 16'hD800 && hv <= 16'hDBFF)
                        begin
                            high_part_next = hv[9:0];
                            mode_next      = MODE_PAIR_BS;
                        end
                        else if (hv >= 16'hDC00 && hv <= 16'hDFFF)
                        begin
                            res_valid      = 1'b1;
                            res.error_code = ERR_STRAY_LO;
                        end
                        else
                        begin
                            mode_next = MODE_BODY;
                            res_valid = 1'b1;
                            res       = utf8_encode({5'd0, hv});
                        end
                    end
                    else
                    begin
                        hex_count_next = 2'd0;
                        hex_value_next = 16'd0;
                        res_valid      = 1'b1;
                        if (hv < 16'hDC00 || hv > 16'hDFFF)
                        begin
                            res.error_code = ERR_PAIR;
                        end
                        else
                        begin
                            mode_next = MODE_BODY;
                            res       = utf8_encode(pair_cp);
                        end
                    end
                end
            endcase
        end

        if (res.string_done || (res.error_code != ERR_NONE))
        begin
            mode_next      = MODE_IDLE;
            hex_count_next = 2'd0;
            hex_value_next = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            hex_count_reg <= 2'd0;
            hex_value_reg <= 16'd0;
            high_part_reg <= 10'd0;
        end
        else if (step)
        begin
            mode_reg      <= mode_next;
            hex_count_reg <= hex_count_next;
            hex_value_reg <= hex_value_next;
            high_part_reg <= high_part_next;
        end
    end

endmodule

### hdl/jsu_out_reg.sv
// Result register between the decoder and the output channel.
module jsu_out_reg import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  result_t    res,
    output logic       can_load,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] byte_a,
    output logic [7:0] byte_b,
    output logic [7:0] byte_c,
    output logic [7:0] byte_d,
    output logic [2:0] byte_count,
    output logic       string_done,
    output logic [2:0] error_code
);

    logic    valid_reg;
    result_t data_reg;

    assign can_load = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign out_valid   = valid_reg;
    assign byte_a      = data_reg.byte_a;
    assign byte_b      = data_reg.byte_b;
    assign byte_c      = data_reg.byte_c;
    assign byte_d      = data_reg.byte_d;
    assign byte_count  = data_reg.byte_count;
    assign string_done = data_reg.string_done;
    assign error_code  = data_reg.error_code;

endmodule

### hdl/json_string_unescape_utf8.sv
// JSON string unescaper, top level: input register, decoder and result register.
// One beat per string byte enters at in_valid/in_stall; the first beat after idle is the
// opening quote. Each beat is captured in an input register, decoded there by the scan
// mode machine and, when it advances, written to the result register if it produces a
// result, so a new beat can be taken every cycle unless in_stall is high. A beat yields
// at most one result beat: one to four UTF-8 bytes, the closing quote (string_done) or
// an error code; the last two leave the block idle again. Bytes that only advance the
// decoder (escape leaders, hex digits, the opening quote) give no result beat. in_stall
// follows out_stall only when a held result blocks the next one.
module json_string_unescape_utf8 import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_byte,
    input  logic       input_ended,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] byte_a,
    output logic [7:0] byte_b,
    output logic [7:0] byte_c,
    output logic [7:0] byte_d,
    output logic [2:0] byte_count,
    output logic       string_done,
    output logic [2:0] error_code
);

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_ended_reg;
    logic       res_valid;
    result_t    res;
    logic       can_load;
    logic       advance;

    assign advance  = s1_valid_reg && (!res_valid || can_load);
    assign in_stall = s1_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg  <= char_byte;
            s1_ended_reg <= input_ended;
        end
    end

    jsu_step u_step
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .c         (s1_byte_reg),
        .ended     (s1_ended_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    jsu_out_reg u_out
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance && res_valid),
        .res         (res),
        .can_load    (can_load),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .byte_a      (byte_a),
        .byte_b      (byte_b),
        .byte_c      (byte_c),
        .byte_d      (byte_d),
        .byte_count  (byte_count),
        .string_done (string_done),
        .error_code  (error_code)
    );

endmodule

### hdl/jsu_checker.sv
// Port-level checks for the JSON string unescaper, bound to the top level.
module jsu_checker import jsu_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] byte_a,
    input logic [7:0] byte_b,
    input logic [7:0] byte_c,
    input logic [7:0] byte_d,
    input logic [2:0] byte_count,
    input logic       string_done,
    input logic [2:0] error_code
);

    // stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(byte_a) && $stable(byte_b)
            && $stable(byte_c) && $stable(byte_d) && $stable(byte_count)
            && $stable(string_done) && $stable(error_code))
        else $error("stalled result beat changed");

    a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (string_done || error_code != ERR_NONE) |->
            byte_count == 3'd0 && byte_a == 8'd0 && byte_b == 8'd0
            && byte_c == 8'd0 && byte_d == 8'd0)
        else $error("end or error beat carries bytes");

    a_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_count == 3'd0 |-> string_done || error_code != ERR_NONE)
        else $error("empty result beat");

    a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> byte_count <= 3'd4 && error_code <= ERR_MAX
            && !(string_done && error_code != ERR_NONE))
        else $error("result fields out of range");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .byte_a      (byte_a),
    .byte_b      (byte_b),
    .byte_c      (byte_c),
    .byte_d      (byte_d),
    .byte_count  (byte_count),
    .string_done (string_done),
    .error_code  (error_code)
);
